@@ hw/rtl/tlnt_pkg.sv @@
// ----------------------------------------------------------------------------
// tlnt_pkg
// Shared types and constants of the two-level name table.
// ----------------------------------------------------------------------------
package tlnt_pkg;

	localparam int unsigned MAX_DIRS_DEF  = 8;
	localparam int unsigned MAX_FILES_DEF = 8;
	localparam int unsigned KEY_W         = 64;
	localparam int unsigned SLOT_W        = 3;

	typedef enum logic [1:0] {
		REQ_CREATE_DIR  = 2'd0,
		REQ_CREATE_FILE = 2'd1,
		REQ_DELETE_FILE = 2'd2,
		REQ_SEARCH_FILE = 2'd3
	} req_kind_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_NO_DIR     = 3'd1,
		ST_NO_FILE    = 3'd2,
		ST_DIRS_FULL  = 3'd3,
		ST_FILES_FULL = 3'd4
	} status_t;

endpackage

@@ hw/rtl/tlnt_req_if.sv @@
// ----------------------------------------------------------------------------
// tlnt_req_if
// Request channel: valid/ready with request kind and keys.
// ----------------------------------------------------------------------------
interface tlnt_req_if
	import tlnt_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic [KEY_W-1:0]  dir_key;
	logic [KEY_W-1:0]  file_key;

	modport source (output valid, output req_type, output dir_key, output file_key,
		input ready);
	modport sink (input valid, input req_type, input dir_key, input file_key,
		output ready);
endinterface

@@ hw/rtl/tlnt_rsp_if.sv @@
// ----------------------------------------------------------------------------
// tlnt_rsp_if
// Response channel: valid/ready with status and directory slot.
// ----------------------------------------------------------------------------
interface tlnt_rsp_if
	import tlnt_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [2:0]        status;
	logic [SLOT_W-1:0] dir_slot;

	modport source (output valid, output status, output dir_slot, input ready);
	modport sink (input valid, input status, input dir_slot, output ready);
endinterface

@@ hw/rtl/two_level_name_table.sv @@
// Create directory goes straight to the result; other requests scan the directories;
// search and delete also scan the files of the matching directory, and delete finally moves
// the last file into the gap. One request in flight; the next is taken the cycle
// after the result is loaded. The scans read one entry per cycle from the directory and
// file memories. Reset clears the directory count and control only; memories keep contents.
// ----------------------------------------------------------------------------
// two_level_name_table
// Directory table with per-directory file lists, held in two synchronous memories
// and scanned sequentially per request.
// ----------------------------------------------------------------------------
module two_level_name_table
	import tlnt_pkg::*;
#(
	parameter int unsigned MAX_DIRS  = MAX_DIRS_DEF,
	parameter int unsigned MAX_FILES = MAX_FILES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	tlnt_req_if.sink   req,
	tlnt_rsp_if.source rsp
);

	localparam int unsigned DIR_AW  = (MAX_DIRS > 1) ? $clog2(MAX_DIRS) : 1;
	localparam int unsigned DCNT_W  = $clog2(MAX_DIRS + 1);
	localparam int unsigned FCNT_W  = $clog2(MAX_FILES + 1);
	localparam int unsigned FIDX_W  = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
	localparam int unsigned FDEPTH  = MAX_DIRS * MAX_FILES;
	localparam int unsigned FILE_AW = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
	localparam logic [FILE_AW-1:0] FSTRIDE = FILE_AW'(MAX_FILES);

	typedef struct packed {
		logic [FCNT_W-1:0] cnt;
		logic [KEY_W-1:0]  name;
	} dir_ent_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DSCAN,
		S_FSCAN,
		S_DEL,
		S_RESP
	} state_t;

	dir_ent_t         dir_mem [MAX_DIRS];
	logic [KEY_W-1:0] file_mem [FDEPTH];

	state_t              state_q;
	req_kind_t           kind_q;
	logic [KEY_W-1:0]    dkey_q;
	logic [KEY_W-1:0]    fkey_q;
	logic [DCNT_W-1:0]   dir_total_q;
	logic [DIR_AW-1:0]   cur_q;
	logic [FCNT_W-1:0]   cnt_q;
	logic [FIDX_W-1:0]   k_q;
	status_t             res_status_q;
	logic [SLOT_W-1:0]   res_slot_q;
	logic                out_valid_q;
	logic [2:0]          out_status_q;
	logic [SLOT_W-1:0]   out_slot_q;

	dir_ent_t            dir_rdata;
	logic [KEY_W-1:0]    file_rdata;

	logic                dir_re, dir_we, file_re, file_we;
	logic [DIR_AW-1:0]   dir_ra, dir_wa;
	dir_ent_t            dir_wd;
	logic [FILE_AW-1:0]  file_ra, file_wa, fbase;
	logic [KEY_W-1:0]    file_wd;
	logic [DCNT_W-1:0]   cur_nxt;
	logic [FCNT_W-1:0]   k_nxt;
	logic                dmatch, fmatch;
	req_kind_t           in_kind;

	assign in_kind = req_kind_t'(req.req_type);
	assign cur_nxt = DCNT_W'(cur_q) + DCNT_W'(1);
	assign k_nxt   = FCNT_W'(k_q) + FCNT_W'(1);
	assign fbase   = FILE_AW'(cur_q) * FSTRIDE;
	assign dmatch  = dir_rdata.name == dkey_q;
	assign fmatch  = file_rdata == fkey_q;

	assign req.ready    = state_q == S_IDLE;
	assign rsp.valid    = out_valid_q;
	assign rsp.status   = out_status_q;
	assign rsp.dir_slot = out_slot_q;

	always_comb begin
		dir_re  = 1'b0;
		dir_ra  = '0;
		dir_we  = 1'b0;
		dir_wa  = '0;
		dir_wd  = '0;
		file_re = 1'b0;
		file_ra = '0;
		file_we = 1'b0;
		file_wa = '0;
		file_wd = fkey_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					if (in_kind == REQ_CREATE_DIR) begin
						dir_we = dir_total_q < DCNT_W'(MAX_DIRS);
						dir_wa = dir_total_q[DIR_AW-1:0];
						dir_wd = '{cnt: '0, name: req.dir_key};
					end else begin
						dir_re = dir_total_q != '0;
					end
				end
			end
			S_DSCAN: begin
				if (dmatch) begin
					if (kind_q == REQ_CREATE_FILE) begin
						if (dir_rdata.cnt < FCNT_W'(MAX_FILES)) begin
							file_we = 1'b1;
							file_wa = fbase + FILE_AW'(dir_rdata.cnt);
							dir_we  = 1'b1;
							dir_wa  = cur_q;
							dir_wd  = '{cnt: dir_rdata.cnt + FCNT_W'(1), name: dkey_q};
						end
					end else begin
						file_re = dir_rdata.cnt != '0;
						file_ra = fbase;
					end
				end else if (cur_nxt < dir_total_q) begin
					dir_re = 1'b1;
					dir_ra = DIR_AW'(cur_nxt);
				end
			end
			S_FSCAN: begin
				if (fmatch) begin
					file_re = kind_q == REQ_DELETE_FILE;
					file_ra = fbase + FILE_AW'(cnt_q - FCNT_W'(1));
				end else if (k_nxt < cnt_q) begin
					file_re = 1'b1;
					file_ra = fbase + FILE_AW'(k_nxt);
				end
			end
			S_DEL: begin
				file_we = 1'b1;
				file_wa = fbase + FILE_AW'(k_q);
				file_wd = file_rdata;
				dir_we  = 1'b1;
				dir_wa  = cur_q;
				dir_wd  = '{cnt: cnt_q - FCNT_W'(1), name: dkey_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (dir_we) begin
			dir_mem[dir_wa] <= dir_wd;
		end
		if (dir_re) begin
			dir_rdata <= dir_mem[dir_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (file_we) begin
			file_mem[file_wa] <= file_wd;
		end
		if (file_re) begin
			file_rdata <= file_mem[file_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dir_total_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp.ready && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						kind_q <= in_kind;
						dkey_q <= req.dir_key;
						fkey_q <= req.file_key;
						cur_q  <= '0;
						if (in_kind == REQ_CREATE_DIR) begin
							if (dir_total_q < DCNT_W'(MAX_DIRS)) begin
								res_status_q <= ST_OK;
								res_slot_q   <= SLOT_W'(dir_total_q);
								dir_total_q  <= dir_total_q + DCNT_W'(1);
							end else begin
								res_status_q <= ST_DIRS_FULL;
								res_slot_q   <= '0;
							end
							state_q <= S_RESP;
						end else if (dir_total_q == '0) begin
							res_status_q <= ST_NO_DIR;
							res_slot_q   <= '0;
							state_q      <= S_RESP;
						end else begin
							state_q <= S_DSCAN;
						end
					end
				end
				S_DSCAN: begin
					if (dmatch) begin
						cnt_q      <= dir_rdata.cnt;
						k_q        <= '0;
						res_slot_q <= SLOT_W'(cur_q);
						if (kind_q == REQ_CREATE_FILE) begin
							res_status_q <= (dir_rdata.cnt < FCNT_W'(MAX_FILES)) ?
								ST_OK : ST_FILES_FULL;
							state_q <= S_RESP;
						end else if (dir_rdata.cnt == '0) begin
							res_status_q <= ST_NO_FILE;
							state_q      <= S_RESP;
						end else begin
							state_q <= S_FSCAN;
						end
					end else if (cur_nxt < dir_total_q) begin
						cur_q <= DIR_AW'(cur_nxt);
					end else begin
						res_status_q <= ST_NO_DIR;
						res_slot_q   <= '0;
						state_q      <= S_RESP;
					end
				end
				S_FSCAN: begin
					if (fmatch) begin
						res_status_q <= ST_OK;
						state_q      <= (kind_q == REQ_DELETE_FILE) ? S_DEL : S_RESP;
					end else if (k_nxt < cnt_q) begin
						k_q <= FIDX_W'(k_nxt);
					end else begin
						res_status_q <= ST_NO_FILE;
						state_q      <= S_RESP;
					end
				end
				S_DEL: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_slot_q   <= res_slot_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dir_total_q <= DCNT_W'(MAX_DIRS))
		else $error("directory count above table size");

	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		dir_total_q != $past(dir_total_q) |-> dir_total_q == $past(dir_total_q) + DCNT_W'(1))
		else $error("directory count moved by other than one");

	a_dscan_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DSCAN |-> DCNT_W'(cur_q) < dir_total_q)
		else $error("directory scan past last directory");

	a_fscan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FSCAN || state_q == S_DEL) |-> FCNT_W'(k_q) < cnt_q)
		else $error("file scan past last file");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("second request taken while one in flight");

endmodule

@@ test/tb_two_level_name_table.sv @@
// ----------------------------------------------------------------------------
// tb_two_level_name_table
// Self-checking bench for the two-level name table: a queue-fed driver offers
// request beats with random gaps, a scoreboard replays each accepted request
// on a local copy of the directory and file tables, and every response beat
// is compared against the oldest predicted outcome.
// ----------------------------------------------------------------------------
module tb_two_level_name_table
	import tlnt_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NDIRS      = MAX_DIRS_DEF;
	localparam int NFILES     = MAX_FILES_DEF;
	localparam int FPOOL      = 12;
	localparam int RAND_ITEMS = 1775;
	localparam int IDLE_PCT   = 28;
	localparam int CALM_FROM  = 4000;
	localparam int CALM_TO    = 8000;
	localparam int HOLD_AT_A  = 2500;
	localparam int HOLD_AT_B  = 12000;
	localparam int HOLD_LEN   = 400;
	localparam int STALL_MAX  = 3000;
	localparam int DRAIN      = 2 * (NDIRS + NFILES + 3);

	typedef struct {
		req_kind_t        kind;
		logic [KEY_W-1:0] dir_key;
		logic [KEY_W-1:0] file_key;
	} request_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] dir_slot;
	} outcome_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	int   cyc    = 0;
	int   errors = 0;

	logic             rq_valid = 1'b0;
	req_kind_t        rq_type  = REQ_CREATE_DIR;
	logic [KEY_W-1:0] rq_dir   = '0;
	logic [KEY_W-1:0] rq_file  = '0;
	logic             rs_ready = 1'b0;
	int               hold_left;
	int               stall_cnt;

	request_t pending[$];
	outcome_t outcomes_due[$];

	logic [KEY_W-1:0] dir_pool [NDIRS];
	logic [KEY_W-1:0] file_pool [FPOOL];

	// scoreboard copy of the tables
	logic [KEY_W-1:0] tbl_dir_names [NDIRS];
	int               tbl_dir_count;
	int               tbl_file_count [NDIRS];
	logic [KEY_W-1:0] tbl_file_names [NDIRS*NFILES];

	wire calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

	tlnt_req_if req ();
	tlnt_rsp_if rsp ();

	assign req.valid    = rq_valid;
	assign req.req_type = rq_type;
	assign req.dir_key  = rq_dir;
	assign req.file_key = rq_file;
	assign rsp.ready    = rs_ready;

	two_level_name_table #(
		.MAX_DIRS (NDIRS),
		.MAX_FILES(NFILES)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	always #5 clk = ~clk;

	always @(posedge clk) cyc <= cyc + 1;

	function automatic outcome_t apply_request(request_t r);
		outcome_t o;
		int       d;
		int       k;
		int       last;
		int       i;
		if (r.kind == REQ_CREATE_DIR) begin
			if (tbl_dir_count >= NDIRS) begin
				o.status   = ST_DIRS_FULL;
				o.dir_slot = '0;
			end else begin
				tbl_dir_names[tbl_dir_count]  = r.dir_key;
				tbl_file_count[tbl_dir_count] = 0;
				o.status   = ST_OK;
				o.dir_slot = SLOT_W'(tbl_dir_count);
				tbl_dir_count++;
			end
			return o;
		end
		d = NDIRS;
		for (i = tbl_dir_count - 1; i >= 0; i--)
			if (tbl_dir_names[i] == r.dir_key) d = i;
		if (d == NDIRS) begin
			o.status   = ST_NO_DIR;
			o.dir_slot = '0;
			return o;
		end
		o.dir_slot = SLOT_W'(d);
		if (r.kind == REQ_CREATE_FILE) begin
			if (tbl_file_count[d] >= NFILES) begin
				o.status = ST_FILES_FULL;
			end else begin
				tbl_file_names[d*NFILES + tbl_file_count[d]] = r.file_key;
				tbl_file_count[d]++;
				o.status = ST_OK;
			end
			return o;
		end
		k = NFILES;
		for (i = tbl_file_count[d] - 1; i >= 0; i--)
			if (tbl_file_names[d*NFILES + i] == r.file_key) k = i;
		if (k == NFILES) begin
			o.status = ST_NO_FILE;
			return o;
		end
		if (r.kind == REQ_DELETE_FILE) begin
			last = tbl_file_count[d] - 1;
			tbl_file_names[d*NFILES + k] = tbl_file_names[d*NFILES + last];
			tbl_file_count[d] = last;
		end
		o.status = ST_OK;
		return o;
	endfunction

	task automatic queue_request(req_kind_t kind, logic [KEY_W-1:0] dk, logic [KEY_W-1:0] fk);
		request_t r;
		r.kind     = kind;
		r.dir_key  = dk;
		r.file_key = fk;
		pending.push_back(r);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin : drive
		request_t nxt;
		if (!arst_n) begin
			rq_valid <= 1'b0;
			rq_type  <= REQ_CREATE_DIR;
			rq_dir   <= '0;
			rq_file  <= '0;
		end else if (!rq_valid || req.ready) begin
			if (pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
				nxt = pending.pop_front();
				rq_valid <= 1'b1;
				rq_type  <= nxt.kind;
				rq_dir   <= nxt.dir_key;
				rq_file  <= nxt.file_key;
			end else begin
				rq_valid <= 1'b0;
			end
		end
	end

	// response ready, with long hold-offs to back the block up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_ready  <= 1'b0;
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rs_ready  <= 1'b0;
		end else if (cyc == HOLD_AT_A || cyc == HOLD_AT_B) begin
			hold_left <= HOLD_LEN;
			rs_ready  <= 1'b0;
		end else begin
			rs_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// scoreboard
	always @(posedge clk) begin : score
		request_t r;
		outcome_t due;
		if (arst_n && req.valid && req.ready) begin
			r.kind     = req_kind_t'(req.req_type);
			r.dir_key  = req.dir_key;
			r.file_key = req.file_key;
			outcomes_due.push_back(apply_request(r));
		end
		if (arst_n && rsp.valid && rsp.ready) begin
			if (outcomes_due.size() == 0) begin
				$error("unexpected response beat: status %0d dir_slot %0d",
					rsp.status, rsp.dir_slot);
				errors++;
			end else begin
				due = outcomes_due.pop_front();
				if (rsp.status !== due.status) begin
					$error("status: expected %0d, actual %0d", due.status, rsp.status);
					errors++;
				end
				if (rsp.dir_slot !== due.dir_slot) begin
					$error("dir_slot: expected %0d, actual %0d", due.dir_slot, rsp.dir_slot);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_MAX) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	initial begin : stimulus
		int               n;
		int               pick;
		req_kind_t        kind;
		logic [KEY_W-1:0] dk;
		logic [KEY_W-1:0] fk;

		tbl_dir_count = 0;
		stall_cnt     = 0;

		// "a" (index 2) is never created, so it always misses
		dir_pool[0] = '0;
		dir_pool[1] = '1;
		dir_pool[2] = 64'h0000_0000_0000_0061;
		dir_pool[3] = 64'h0000_0000_686f_6d65;
		dir_pool[4] = 64'h0000_0000_0075_7372;
		dir_pool[5] = 64'h0000_0000_0065_7463;
		dir_pool[6] = 64'h7379_7374_656d_3332;
		dir_pool[7] = {$urandom, $urandom};
		file_pool[0] = '0;
		file_pool[1] = '1;
		for (n = 2; n < FPOOL; n++) file_pool[n] = {$urandom, $urandom};

		// directed
		queue_request(REQ_SEARCH_FILE, dir_pool[0], file_pool[0]);
		queue_request(REQ_CREATE_DIR,  dir_pool[0], {$urandom, $urandom});
		queue_request(REQ_CREATE_DIR,  dir_pool[1], '1);
		queue_request(REQ_CREATE_FILE, dir_pool[0], file_pool[0]);
		queue_request(REQ_CREATE_FILE, dir_pool[0], file_pool[1]);
		queue_request(REQ_SEARCH_FILE, dir_pool[0], file_pool[1]);
		queue_request(REQ_SEARCH_FILE, dir_pool[0], file_pool[5]);
		queue_request(REQ_DELETE_FILE, dir_pool[0], file_pool[0]);
		queue_request(REQ_SEARCH_FILE, dir_pool[0], file_pool[1]);
		queue_request(REQ_DELETE_FILE, dir_pool[0], file_pool[0]);
		for (n = 0; n < NFILES; n++)
			queue_request(REQ_CREATE_FILE, dir_pool[1], file_pool[n]);
		queue_request(REQ_CREATE_FILE, dir_pool[1], file_pool[9]);
		queue_request(REQ_CREATE_DIR,  dir_pool[1], '0);
		for (n = 3; n < NDIRS; n++)
			queue_request(REQ_CREATE_DIR, dir_pool[n], {$urandom, $urandom});
		queue_request(REQ_CREATE_DIR,  dir_pool[2], {$urandom, $urandom});
		queue_request(REQ_CREATE_FILE, dir_pool[1], file_pool[10]);
		queue_request(REQ_DELETE_FILE, dir_pool[1], file_pool[3]);
		queue_request(REQ_SEARCH_FILE, dir_pool[2], file_pool[3]);

		// random, mostly on known names so the file lists churn
		for (n = 0; n < RAND_ITEMS; n++) begin
			pick = $urandom_range(99);
			if (pick < 8)
				kind = REQ_CREATE_DIR;
			else if (pick < 43)
				kind = REQ_CREATE_FILE;
			else if (pick < 68)
				kind = REQ_DELETE_FILE;
			else
				kind = REQ_SEARCH_FILE;
			dk = ($urandom_range(99) < 88) ? dir_pool[$urandom_range(NDIRS-1)]
				: {$urandom, $urandom};
			fk = ($urandom_range(99) < 85) ? file_pool[$urandom_range(FPOOL-1)]
				: {$urandom, $urandom};
			queue_request(kind, dk, fk);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || rq_valid) @(posedge clk);
		while (outcomes_due.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (outcomes_due.size() != 0) begin
			$error("response beats missing: %0d", outcomes_due.size());
			errors++;
		end
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
